>>> rtl/tcp_newreno_window_control_unit_assert.svh
// assertion macros for the window control unit and its checker
`ifndef TCP_NEWRENO_WINDOW_CONTROL_UNIT_ASSERT_SVH
`define TCP_NEWRENO_WINDOW_CONTROL_UNIT_ASSERT_SVH

// property checked on the rising clock, off while reset is low
`define TNWC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication into the next cycle
`define TNWC_ASSERT_NEXT(label, ante, cons, msg) \
  `TNWC_ASSERT(label, (ante) |=> (cons), msg)

`endif

>>> rtl/tnwc_pkg.sv
// shared types, constants and helpers for the window control unit
`timescale 1ns / 1ps

package tnwc_pkg;

  localparam int SEQ_BITS  = 32;
  localparam int WIDE_BITS = (SEQ_BITS > 32) ? SEQ_BITS : 32;
  localparam int WIN_BITS  = 32;
  localparam int ADV_BITS  = 16;
  localparam int CNT_BITS  = 8;
  localparam int CFG_IDX_BITS = 2;

  typedef logic [SEQ_BITS-1:0]  seq_t;
  typedef logic [WIDE_BITS-1:0] wide_t;
  typedef logic [WIN_BITS-1:0]  win_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  typedef enum logic [1:0] {
    MODE_SS = 2'd0,
    MODE_CA = 2'd1,
    MODE_FR = 2'd2
  } mode_e;

  localparam logic OP_TIMEOUT = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_WINDOW    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DUP_LIMIT      = 2'd2;

  localparam win_t INIT_WINDOW_RST    = 32'd1;
  localparam win_t INIT_THRESHOLD_RST = 32'd64;
  localparam cnt_t DUP_LIMIT_RST      = 8'd3;

  localparam win_t WIN_MAX = '1;
  localparam cnt_t CNT_MAX = '1;

  typedef struct packed {
    win_t init_window;
    win_t init_threshold;
    cnt_t dup_limit;
  } cfg_t;

  typedef struct packed {
    mode_e mode;
    win_t  window;
    win_t  threshold;
    cnt_t  dup_count;
    seq_t  expected_mark;
    seq_t  next_seq;
    cnt_t  loss_count;
  } wnd_state_t;

  function automatic seq_t win_to_seq(input win_t w);
    wide_t wide;
    wide = wide_t'(w);
    return seq_t'(wide);
  endfunction

endpackage

>>> rtl/tcp_newreno_window_control_unit.sv
// top level of the congestion window control unit
// latency: an accepted request is held in the request register, and its result in the result register
// throughput: one request per cycle while the result is not stalled, set by the single-pass update
// between the request register and the result register
// reset: config registers load 1 / 64 / 3, window state loads its reset values at once
`timescale 1ns / 1ps

module tcp_newreno_window_control_unit import tnwc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [WIN_BITS-1:0]     cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    op_i,
  input  logic [ADV_BITS-1:0]     ack_advance_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [WIN_BITS-1:0]     window_o,
  output logic [WIN_BITS-1:0]     threshold_o,
  output logic [1:0]              mode_o,
  output logic [31:0]             next_sequence_o,
  output logic                    loss_seen_o
);

  cfg_t       cfg, cfg_next;
  logic       reload;
  wnd_state_t state_q, state_d, step_state;
  logic       step_loss;
  logic       in_valid_q;
  logic       op_q;
  logic [ADV_BITS-1:0] adv_q;
  logic       fire;
  logic       out_valid_q;
  win_t       window_q, threshold_q;
  logic [1:0] mode_q;
  logic [31:0] next_sequence_q;
  logic       loss_q;
  wide_t      seq_wide;

  tnwc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .cfg_next_o  (cfg_next),
    .reload_o    (reload)
  );

  tnwc_step u_step (
    .state_i     (state_q),
    .op_i        (op_q),
    .adv_i       (adv_q),
    .dup_limit_i (cfg.dup_limit),
    .state_o     (step_state),
    .loss_o      (step_loss)
  );

  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  always_comb begin
    state_d = state_q;
    if (reload) begin
      state_d.window    = cfg_next.init_window;
      state_d.threshold = cfg_next.init_threshold;
    end else if (fire) begin
      state_d = step_state;
    end
  end

  assign seq_wide = wide_t'(step_state.next_seq);

  // window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode          <= MODE_SS;
      state_q.window        <= INIT_WINDOW_RST;
      state_q.threshold     <= INIT_THRESHOLD_RST;
      state_q.dup_count     <= '0;
      state_q.expected_mark <= win_to_seq(INIT_WINDOW_RST);
      state_q.next_seq      <= '0;
      state_q.loss_count    <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  // request and result valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q  <= op_i;
      adv_q <= ack_advance_i;
    end
    if (fire) begin
      window_q        <= step_state.window;
      threshold_q     <= step_state.threshold;
      mode_q          <= step_state.mode;
      next_sequence_q <= seq_wide[31:0];
      loss_q          <= step_loss;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign window_o        = window_q;
  assign threshold_o     = threshold_q;
  assign mode_o          = mode_q;
  assign next_sequence_o = next_sequence_q;
  assign loss_seen_o     = loss_q;

endmodule

>>> rtl/tnwc_cfg.sv
// configuration registers with reload request toward the window state
`timescale 1ns / 1ps

module tnwc_cfg import tnwc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [WIN_BITS-1:0]     cfg_data_i,
  output cfg_t                    cfg_o,
  output cfg_t                    cfg_next_o,
  output logic                    reload_o
);

  cfg_t cfg_q, cfg_d;
  logic hit;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    hit   = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_INIT_WINDOW: begin
          cfg_d.init_window = cfg_data_i;
          hit = 1'b1;
        end
        CFG_INIT_THRESHOLD: begin
          cfg_d.init_threshold = cfg_data_i;
          hit = 1'b1;
        end
        CFG_DUP_LIMIT: begin
          cfg_d.dup_limit = cfg_data_i[CNT_BITS-1:0];
          hit = 1'b1;
        end
        default: begin
          hit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.init_window    <= INIT_WINDOW_RST;
      cfg_q.init_threshold <= INIT_THRESHOLD_RST;
      cfg_q.dup_limit      <= DUP_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o      = cfg_q;
  assign cfg_next_o = cfg_d;
  assign reload_o   = hit;

endmodule

>>> rtl/tnwc_step.sv
// next window state for one ack or timeout request
`timescale 1ns / 1ps

module tnwc_step import tnwc_pkg::*; (
  input  wnd_state_t           state_i,
  input  logic                 op_i,
  input  logic [ADV_BITS-1:0]  adv_i,
  input  cnt_t                 dup_limit_i,
  output wnd_state_t           state_o,
  output logic                 loss_o
);

  wnd_state_t s;
  seq_t       diff;
  logic       loss;

  always_comb begin
    s    = state_i;
    diff = '0;
    loss = 1'b0;
    if (op_i == OP_TIMEOUT) begin
      case (s.mode)
        MODE_FR: begin
          s.window    = s.window >> 1;
          s.threshold = s.window;
          s.mode      = MODE_CA;
        end
        MODE_CA: begin
          s.window    = win_t'(1);
          s.threshold = win_t'(1);
          s.mode      = MODE_SS;
        end
        default: begin
          s.threshold = s.window >> 1;
          s.window    = win_t'(1);
        end
      endcase
    end else begin
      s.next_seq = s.next_seq + seq_t'(adv_i);
      diff       = s.next_seq - s.expected_mark;
      if (!diff[SEQ_BITS-1]) begin
        // new data acked up to the mark
        s.dup_count     = '0;
        s.expected_mark = s.next_seq + win_to_seq(s.window);
        s.loss_count    = '0;
        if (s.mode == MODE_FR) begin
          s.mode = MODE_CA;
        end
      end else begin
        if (s.dup_count != CNT_MAX) begin
          s.dup_count = s.dup_count + cnt_t'(1);
        end
        if (s.mode != MODE_FR || s.dup_count == dup_limit_i) begin
          loss = 1'b1;
          if (s.loss_count != CNT_MAX) begin
            s.loss_count = s.loss_count + cnt_t'(1);
          end
          case (s.mode)
            MODE_FR: begin
              s.window    = s.window >> 1;
              s.threshold = s.window;
              s.mode      = MODE_CA;
            end
            MODE_CA: begin
              s.mode = MODE_FR;
            end
            default: begin
              s.threshold = s.window >> 1;
              s.window    = win_t'(1);
              s.mode      = MODE_SS;
            end
          endcase
        end
      end

      // window growth or shrink
      if (s.mode == MODE_FR && s.loss_count == '0) begin
        s.window    = s.window >> 1;
        s.threshold = s.window;
      end else if (s.mode == MODE_SS) begin
        s.window = s.window[WIN_BITS-1] ? WIN_MAX : {s.window[WIN_BITS-2:0], 1'b0};
        if (s.window >= s.threshold) begin
          s.mode = MODE_CA;
        end
      end else if (s.mode == MODE_CA) begin
        if (s.window != WIN_MAX) begin
          s.window = s.window + win_t'(1);
        end
      end
    end
  end

  assign state_o = s;
  assign loss_o  = loss;

endmodule

>>> rtl/tnwc_checker.sv
// port-level checker for the window control unit, bound to the top level
`timescale 1ns / 1ps
`include "tcp_newreno_window_control_unit_assert.svh"

module tnwc_checker import tnwc_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [WIN_BITS-1:0]     window_o,
  input logic [WIN_BITS-1:0]     threshold_o,
  input logic [1:0]              mode_o,
  input logic [31:0]             next_sequence_o,
  input logic                    loss_seen_o
);

  // stalled result stays
  `TNWC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")

  `TNWC_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(window_o) && $stable(threshold_o) && $stable(next_sequence_o) && $stable(mode_o), "stalled result changed")

  // mode code 3 never shows
  `TNWC_ASSERT(a_mode_legal, out_valid_o |-> (mode_o != 2'd3), "illegal mode on result")

  // loss in slow start restarts at one, then doubles
  `TNWC_ASSERT(a_ss_loss_window, out_valid_o && loss_seen_o && (mode_o == MODE_SS) |-> (window_o == 32'd2), "slow start loss window wrong")

endmodule

bind tcp_newreno_window_control_unit tnwc_checker u_tnwc_checker (.*);

>>> sim/testbench.sv
// self-checking testbench for the tcp newreno congestion window control unit
`timescale 1ns / 1ps

module testbench;
  import tnwc_pkg::*;

  localparam logic                    OP_ACK         = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED     = 2'd3;
  localparam int                      WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic                op;
    logic [ADV_BITS-1:0] adv;
  } ack_event_t;

  typedef struct {
    win_t        window;
    win_t        threshold;
    mode_e       mode;
    logic [31:0] next_sequence;
    logic        loss_seen;
  } window_update_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_valid_i   = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i   = '0;
  logic [WIN_BITS-1:0]     cfg_data_i    = '0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_ready_o;
  logic                    op_i          = OP_ACK;
  logic [ADV_BITS-1:0]     ack_advance_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i   = 1'b0;
  logic [WIN_BITS-1:0]     window_o;
  logic [WIN_BITS-1:0]     threshold_o;
  logic [1:0]              mode_o;
  logic [31:0]             next_sequence_o;
  logic                    loss_seen_o;

  ack_event_t     events_q[$];
  window_update_t updates_q[$];

  // shadow of the block's registers and window state
  win_t  reg_init_window    = INIT_WINDOW_RST;
  win_t  reg_init_threshold = INIT_THRESHOLD_RST;
  cnt_t  reg_dup_limit      = DUP_LIMIT_RST;
  mode_e st_mode            = MODE_SS;
  win_t  st_window          = INIT_WINDOW_RST;
  win_t  st_threshold       = INIT_THRESHOLD_RST;
  cnt_t  st_dup             = '0;
  cnt_t  st_loss            = '0;
  seq_t  st_mark            = seq_t'(INIT_WINDOW_RST);
  seq_t  st_next            = '0;

  logic in_taken  = 1'b0;
  bit   in_burst  = 1'b0;
  bit   out_burst = 1'b0;
  int   in_gap    = 0;
  int   out_stall = 0;
  int   idle_cycles = 0;
  int   mismatches  = 0;

  tcp_newreno_window_control_unit u_top (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic void halve_into_avoidance();
    st_window    = st_window >> 1;
    st_threshold = st_window;
    st_mode      = MODE_CA;
  endfunction

  function automatic void drop_to_one();
    st_threshold = st_window >> 1;
    st_window    = win_t'(1);
  endfunction

  function automatic void load_register(input logic [CFG_IDX_BITS-1:0] idx, input win_t data);
    case (idx)
      CFG_INIT_WINDOW:    reg_init_window = data;
      CFG_INIT_THRESHOLD: reg_init_threshold = data;
      CFG_DUP_LIMIT:      reg_dup_limit = cnt_t'(data);
      default:            return;
    endcase
    st_window    = reg_init_window;
    st_threshold = reg_init_threshold;
  endfunction

  function automatic window_update_t apply_event(input logic op, input logic [ADV_BITS-1:0] adv);
    window_update_t upd;
    seq_t           lead;
    logic           lost;
    lost = 1'b0;
    if (op == OP_TIMEOUT) begin
      case (st_mode)
        MODE_FR: halve_into_avoidance();
        MODE_CA: begin
          st_window    = win_t'(1);
          st_threshold = win_t'(1);
          st_mode      = MODE_SS;
        end
        default: drop_to_one();
      endcase
    end else begin
      st_next = st_next + seq_t'(adv);
      lead    = st_next - st_mark;
      if (!lead[SEQ_BITS-1]) begin
        st_dup  = '0;
        st_loss = '0;
        st_mark = st_next + seq_t'(st_window);
        if (st_mode == MODE_FR) st_mode = MODE_CA;
      end else begin
        if (st_dup != CNT_MAX) st_dup = st_dup + 1'b1;
        if (st_mode != MODE_FR || st_dup == reg_dup_limit) begin
          lost = 1'b1;
          if (st_loss != CNT_MAX) st_loss = st_loss + 1'b1;
          case (st_mode)
            MODE_FR: halve_into_avoidance();
            MODE_CA: st_mode = MODE_FR;
            default: drop_to_one();
          endcase
        end
      end
      if (st_mode == MODE_FR && st_loss == '0) begin
        st_window    = st_window >> 1;
        st_threshold = st_window;
      end else if (st_mode == MODE_SS) begin
        st_window = st_window[WIN_BITS-1] ? WIN_MAX : st_window << 1;
        if (st_window >= st_threshold) st_mode = MODE_CA;
      end else if (st_mode == MODE_CA && st_window != WIN_MAX) begin
        st_window = st_window + 1'b1;
      end
    end
    upd.window        = st_window;
    upd.threshold     = st_threshold;
    upd.mode          = st_mode;
    upd.next_sequence = st_next[31:0];
    upd.loss_seen     = lost;
    return upd;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v, act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (events_q.size() != 0) begin
        ack_event_t ev;
        ev = events_q.pop_front();
        op_i          <= ev.op;
        ack_advance_i <= ev.adv;
        in_valid_i    <= 1'b1;
        in_gap = in_burst ? 0 : pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      out_stall = out_burst ? 0 : pick_gap();
    end
  end

  // prediction on accepted requests and register writes
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && cfg_valid_i && cfg_ready_o) load_register(cfg_index_i, cfg_data_i);
    if (in_taken) updates_q.push_back(apply_event(op_i, ack_advance_i));
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (updates_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual window %0h", $time, window_o);
        mismatches++;
      end else begin
        window_update_t upd;
        upd = updates_q.pop_front();
        check_field("window", upd.window, window_o);
        check_field("threshold", upd.threshold, threshold_o);
        check_field("mode", 32'(upd.mode), 32'(mode_o));
        check_field("next_sequence", upd.next_sequence, next_sequence_o);
        check_field("loss_seen", 32'(upd.loss_seen), 32'(loss_seen_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_event(input logic op, input logic [ADV_BITS-1:0] adv);
    ack_event_t ev;
    ev.op  = op;
    ev.adv = adv;
    events_q.push_back(ev);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (events_q.size() != 0 || in_valid_i || updates_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input win_t data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!(cfg_valid_i && cfg_ready_o));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_random_event();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10)      push_event(OP_TIMEOUT, ADV_BITS'($urandom));
    else if (r < 45) push_event(OP_ACK, '0);
    else if (r < 70) push_event(OP_ACK, ADV_BITS'($urandom_range(1, 4)));
    else if (r < 85) push_event(OP_ACK, ADV_BITS'($urandom_range(1, 64)));
    else if (r < 95) push_event(OP_ACK, ADV_BITS'($urandom));
    else             push_event(OP_ACK, '1);
  endtask

  function automatic win_t pick_window();
    case ($urandom_range(0, 4))
      0:       return win_t'(1);
      1:       return win_t'($urandom_range(1, 16));
      2:       return WIN_MAX;
      3:       return win_t'($urandom_range(1, 1024));
      default: return win_t'($urandom) | win_t'(1);
    endcase
  endfunction

  function automatic win_t pick_threshold();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return win_t'($urandom_range(1, 64));
      2:       return WIN_MAX;
      default: return win_t'($urandom);
    endcase
  endfunction

  function automatic win_t pick_limit();
    case ($urandom_range(0, 3))
      0:       return win_t'(1);
      1:       return win_t'(CNT_MAX);
      2:       return win_t'($urandom_range(1, 5));
      default: return win_t'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: walk through every mode and every timeout rule
    push_event(OP_ACK, 16'd1);
    repeat (4) push_event(OP_ACK, '0);
    push_event(OP_TIMEOUT, '0);
    push_event(OP_ACK, '0);
    push_event(OP_ACK, '0);
    push_event(OP_TIMEOUT, '0);
    push_event(OP_ACK, '1);
    push_event(OP_TIMEOUT, '1);
    push_event(OP_TIMEOUT, '0);
    wait_idle();

    // unused index, then saturating window and a mark that wraps
    write_reg(CFG_UNUSED, 32'h1234_5678);
    write_reg(CFG_INIT_WINDOW, 32'h8000_0000);
    write_reg(CFG_INIT_THRESHOLD, WIN_MAX);
    push_event(OP_ACK, '1);
    push_event(OP_ACK, 16'd1);
    push_event(OP_ACK, '0);
    wait_idle();

    // zero duplicate limit keeps fast recovery from ever seeing a loss
    write_reg(CFG_DUP_LIMIT, '0);
    write_reg(CFG_INIT_WINDOW, 32'd4);
    write_reg(CFG_INIT_THRESHOLD, 32'd2);
    repeat (4) push_event(OP_ACK, '0);
    wait_idle();

    write_reg(CFG_INIT_WINDOW, WIN_MAX);
    write_reg(CFG_INIT_THRESHOLD, '0);
    push_event(OP_TIMEOUT, 16'h5555);
    push_event(OP_ACK, 16'hAAAA);
    wait_idle();

    for (int phase = 0; phase < 9; phase++) begin
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, win_t'($urandom));
      write_reg(CFG_DUP_LIMIT, pick_limit());
      write_reg(CFG_INIT_THRESHOLD, pick_threshold());
      write_reg(CFG_INIT_WINDOW, pick_window());
      repeat (64) push_random_event();
      wait_idle();
    end

    // long duplicate run saturates the duplicate counter
    in_burst  = 1'b0;
    out_burst = 1'b0;
    write_reg(CFG_DUP_LIMIT, win_t'(CNT_MAX));
    write_reg(CFG_INIT_WINDOW, 32'd8);
    write_reg(CFG_INIT_THRESHOLD, 32'd4);
    repeat (300) push_event(OP_ACK, '0);
    repeat (3) push_event(OP_ACK, '1);
    wait_idle();

    repeat (8) @(posedge clk_i);
    if (updates_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, updates_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/tnwc_pkg.sv
rtl/tnwc_cfg.sv
rtl/tnwc_step.sv
rtl/tcp_newreno_window_control_unit.sv
rtl/tnwc_checker.sv
sim/testbench.sv
